@@ src/chacha_pkg.sv @@
// Shared types and constants for the ChaCha keystream block core.
// Holds the controller/datapath command and status structs, register indexes
// and the "expand 32-byte k" words. No dependencies.
package chacha_pkg;

  localparam int unsigned NumWords  = 16;
  localparam int unsigned WordW     = 32;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned RoundW    = 5;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned CounterW  = 64;

  localparam logic [RoundW-1:0] RoundsReset = 5'd20;

  localparam logic [CfgIdxW-1:0] CFG_ROUND_COUNT = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_01      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEY_23      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_KEY_45      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_KEY_67      = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_NONCE       = 3'd5;

  localparam logic [WordW-1:0] SIGMA [4] = '{
    32'h6170_7865, 32'h3320_646E, 32'h7962_2D32, 32'h6B20_6574
  };

  typedef struct packed {
    logic            load;
    logic            step;
    logic            diag;
    logic            second;
    logic            emit;
    logic [IdxW-1:0] idx;
  } chacha_cmd_t;

  typedef struct packed {
    logic [RoundW-1:0] round_count;
    logic              out_free;
  } chacha_sts_t;

endpackage

@@ src/chacha_dp.sv @@
// ChaCha datapath: configuration registers, 16-word working state, four
// parallel quarter-round lanes (one half quarter round per step) and output register.
// Depends on chacha_pkg.
module chacha_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  chacha_pkg::chacha_cmd_t        cmd_i,
  output chacha_pkg::chacha_sts_t        sts_o,
  input  logic [chacha_pkg::CounterW-1:0] block_counter_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [chacha_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [chacha_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [chacha_pkg::WordW-1:0]   keystream_word_o,
  output logic [chacha_pkg::IdxW-1:0]    word_index_o,
  output logic                           last_word_o
);
  import chacha_pkg::*;

  logic [RoundW-1:0]   rounds_q;
  logic [CfgDataW-1:0] key01_q, key23_q, key45_q, key67_q, nonce_q;
  logic [CounterW-1:0] cnt_q;
  logic [WordW-1:0]    w_q [NumWords];
  logic [WordW-1:0]    w_d [NumWords];
  logic [WordW-1:0]    st  [NumWords];
  logic [WordW-1:0]    na  [4];
  logic [WordW-1:0]    nb  [4];
  logic [WordW-1:0]    nc  [4];
  logic [WordW-1:0]    nd  [4];
  logic                out_valid_q;
  logic [WordW-1:0]    out_word_q;
  logic [IdxW-1:0]     out_idx_q;
  logic                out_last_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rounds_q <= RoundsReset;
      key01_q  <= '0;
      key23_q  <= '0;
      key45_q  <= '0;
      key67_q  <= '0;
      nonce_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ROUND_COUNT: rounds_q <= cfg_data_i[RoundW-1:0];
        CFG_KEY_01:      key01_q  <= cfg_data_i;
        CFG_KEY_23:      key23_q  <= cfg_data_i;
        CFG_KEY_45:      key45_q  <= cfg_data_i;
        CFG_KEY_67:      key67_q  <= cfg_data_i;
        CFG_NONCE:       nonce_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    st[0]  = SIGMA[0];
    st[1]  = SIGMA[1];
    st[2]  = SIGMA[2];
    st[3]  = SIGMA[3];
    st[4]  = key01_q[31:0];
    st[5]  = key01_q[63:32];
    st[6]  = key23_q[31:0];
    st[7]  = key23_q[63:32];
    st[8]  = key45_q[31:0];
    st[9]  = key45_q[63:32];
    st[10] = key67_q[31:0];
    st[11] = key67_q[63:32];
    st[12] = cnt_q[31:0];
    st[13] = cnt_q[63:32];
    st[14] = nonce_q[31:0];
    st[15] = nonce_q[63:32];
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    localparam logic [IdxW-1:0] AI = 4'(g);
    localparam logic [IdxW-1:0] BC = 4'(4 + g);
    localparam logic [IdxW-1:0] CC = 4'(8 + g);
    localparam logic [IdxW-1:0] DC = 4'(12 + g);
    localparam logic [IdxW-1:0] BD = 4'(4 + ((g + 1) % 4));
    localparam logic [IdxW-1:0] CD = 4'(8 + ((g + 2) % 4));
    localparam logic [IdxW-1:0] DD = 4'(12 + ((g + 3) % 4));

    logic [WordW-1:0] b_op, c_op, d_op, x1, x2;

    always_comb begin
      b_op  = cmd_i.diag ? w_q[BD] : w_q[BC];
      c_op  = cmd_i.diag ? w_q[CD] : w_q[CC];
      d_op  = cmd_i.diag ? w_q[DD] : w_q[DC];
      na[g] = w_q[AI] + b_op;
      x1    = d_op ^ na[g];
      nd[g] = cmd_i.second ? {x1[23:0], x1[31:24]} : {x1[15:0], x1[31:16]};
      nc[g] = c_op + nd[g];
      x2    = b_op ^ nc[g];
      nb[g] = cmd_i.second ? {x2[24:0], x2[31:25]} : {x2[19:0], x2[31:20]};
    end
  end

  always_comb begin
    w_d = w_q;
    if (cmd_i.load) begin
      w_d     = st;
      w_d[12] = block_counter_i[31:0];
      w_d[13] = block_counter_i[63:32];
    end else if (cmd_i.step) begin
      w_d[0]  = na[0];
      w_d[1]  = na[1];
      w_d[2]  = na[2];
      w_d[3]  = na[3];
      w_d[4]  = cmd_i.diag ? nb[3] : nb[0];
      w_d[5]  = cmd_i.diag ? nb[0] : nb[1];
      w_d[6]  = cmd_i.diag ? nb[1] : nb[2];
      w_d[7]  = cmd_i.diag ? nb[2] : nb[3];
      w_d[8]  = cmd_i.diag ? nc[2] : nc[0];
      w_d[9]  = cmd_i.diag ? nc[3] : nc[1];
      w_d[10] = cmd_i.diag ? nc[0] : nc[2];
      w_d[11] = cmd_i.diag ? nc[1] : nc[3];
      w_d[12] = cmd_i.diag ? nd[1] : nd[0];
      w_d[13] = cmd_i.diag ? nd[2] : nd[1];
      w_d[14] = cmd_i.diag ? nd[3] : nd[2];
      w_d[15] = cmd_i.diag ? nd[0] : nd[3];
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    if (cmd_i.load) begin
      cnt_q <= block_counter_i;
    end
    if (cmd_i.emit) begin
      out_word_q <= w_q[cmd_i.idx] + st[cmd_i.idx];
      out_idx_q  <= cmd_i.idx;
      out_last_q <= (cmd_i.idx == 4'(NumWords - 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.round_count = rounds_q;
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign keystream_word_o = out_word_q;
  assign word_index_o     = out_idx_q;
  assign last_word_o      = out_last_q;

endmodule

@@ src/chacha_ctrl.sv @@
// ChaCha controller: state machine sequencing load, rounds and word output.
// Drives datapath commands, reads datapath status. Depends on chacha_pkg.
module chacha_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  output chacha_pkg::chacha_cmd_t cmd_o,
  input  chacha_pkg::chacha_sts_t sts_i
);
  import chacha_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ROUND = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [RoundW-1:0] done_q, done_d;
  logic              half_q, half_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d      = state_q;
    done_d       = done_q;
    half_d       = half_q;
    idx_d        = idx_q;
    cmd_o        = '0;
    cmd_o.diag   = done_q[0];
    cmd_o.second = half_q;
    cmd_o.idx    = idx_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          done_d     = '0;
          half_d     = 1'b0;
          idx_d      = '0;
          state_d    = (sts_i.round_count == '0) ? S_EMIT : S_ROUND;
        end
      end
      S_ROUND: begin
        cmd_o.step = 1'b1;
        half_d     = !half_q;
        if (half_q) begin
          done_d = done_q + 5'd1;
          if (done_d == sts_i.round_count) begin
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          idx_d      = idx_q + 4'd1;
          if (idx_q == 4'(NumWords - 1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= '0;
      half_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      half_q  <= half_d;
      idx_q   <= idx_d;
    end
  end

  a_round_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND) |-> (done_q < sts_i.round_count))
    else $error("round counter passed configured count");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && (idx_q == 4'(NumWords - 1))) |=> (state_q == S_IDLE))
    else $error("controller did not return to idle after last word");

  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_ROUND || state_q == S_EMIT) && (idx_q == '0))
    else $error("load did not start a block");

endmodule

@@ src/chacha_keystream_block_core.sv @@
// Top level of the ChaCha keystream block core.
// Joins chacha_ctrl and chacha_dp. Depends on chacha_pkg.
//
// Usage: one transfer on the input channel (in_valid_i high, in_stall_o low)
// carries a 64-bit block counter. The core builds the start state from the
// constant words, the key, the counter and the nonce, runs round_count single
// rounds (column, diagonal, alternating) and returns 16 transfers on the output
// channel: keystream words 0..15, last_word_o high on word 15.
// Each round runs as two half-quarter-round steps in the shared quarter-round
// lanes. After the rounds the keystream words leave in order, one word a cycle
// while out_stall_i is low.
// in_stall_o stays high from the input transfer until the last word enters the
// output register. A high out_stall_i holds the output register and pauses
// word generation. Configuration writes (cfg_ready_o is always high) are taken
// any time but may change only while no block is in flight.
// Reset clears control state and loads round_count = 20, key and nonce zero.
module chacha_keystream_block_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [chacha_pkg::CounterW-1:0] block_counter_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [chacha_pkg::WordW-1:0]    keystream_word_o,
  output logic [chacha_pkg::IdxW-1:0]     word_index_o,
  output logic                            last_word_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [chacha_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [chacha_pkg::CfgDataW-1:0] cfg_data_i
);
  import chacha_pkg::*;

  chacha_cmd_t cmd;
  chacha_sts_t sts;

  chacha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  chacha_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .block_counter_i  (block_counter_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .keystream_word_o (keystream_word_o),
    .word_index_o     (word_index_o),
    .last_word_o      (last_word_o)
  );

endmodule

@@ sim/chacha_keystream_checker.sv @@
// Scoreboard for the ChaCha keystream block core: tracks register writes,
// predicts the 16 words of every accepted block and checks each output
// transfer in order. Depends on chacha_pkg.
module chacha_keystream_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [chacha_pkg::CounterW-1:0] block_counter_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [chacha_pkg::WordW-1:0]    keystream_word_i,
  input  logic [chacha_pkg::IdxW-1:0]     word_index_i,
  input  logic                            last_word_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [chacha_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [chacha_pkg::CfgDataW-1:0] cfg_data_i,
  output int unsigned                     failures_o,
  output int unsigned                     words_due_o,
  output int unsigned                     words_checked_o
);

  import chacha_pkg::*;

  typedef logic [NumWords-1:0][WordW-1:0] block_t;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic [IdxW-1:0]  index;
    logic             last;
  } ks_word_t;

  logic [RoundW-1:0]   rounds_cfg;
  logic [CfgDataW-1:0] key_01;
  logic [CfgDataW-1:0] key_23;
  logic [CfgDataW-1:0] key_45;
  logic [CfgDataW-1:0] key_67;
  logic [CfgDataW-1:0] nonce_cfg;

  ks_word_t    keystream_due [$];
  block_t      predicted;
  ks_word_t    want;
  ks_word_t    got;
  int unsigned failures;
  int unsigned words_checked;
  int unsigned words_due;

  assign failures_o      = failures;
  assign words_due_o     = words_due;
  assign words_checked_o = words_checked;

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic block_t quarter(input block_t s, input int a, input int b,
                                     input int c, input int d);
    block_t t;
    t = s;
    t[a] = t[a] + t[b]; t[d] = rotl(t[d] ^ t[a], 16);
    t[c] = t[c] + t[d]; t[b] = rotl(t[b] ^ t[c], 12);
    t[a] = t[a] + t[b]; t[d] = rotl(t[d] ^ t[a], 8);
    t[c] = t[c] + t[d]; t[b] = rotl(t[b] ^ t[c], 7);
    return t;
  endfunction

  function automatic block_t column_pass(input block_t s);
    block_t t;
    t = quarter(s, 0, 4, 8, 12);
    t = quarter(t, 1, 5, 9, 13);
    t = quarter(t, 2, 6, 10, 14);
    t = quarter(t, 3, 7, 11, 15);
    return t;
  endfunction

  function automatic block_t diagonal_pass(input block_t s);
    block_t t;
    t = quarter(s, 0, 5, 10, 15);
    t = quarter(t, 1, 6, 11, 12);
    t = quarter(t, 2, 7, 8, 13);
    t = quarter(t, 3, 4, 9, 14);
    return t;
  endfunction

  function automatic block_t keystream_block(input logic [CounterW-1:0] counter);
    block_t      start;
    block_t      work;
    block_t      sum;
    int unsigned done;
    int          i;
    for (i = 0; i < 4; i++) start[i] = SIGMA[i];
    start[5:4]   = key_01;
    start[7:6]   = key_23;
    start[9:8]   = key_45;
    start[11:10] = key_67;
    start[13:12] = counter;
    start[15:14] = nonce_cfg;
    work = start;
    done = 0;
    while (done + 2 <= rounds_cfg) begin
      work = diagonal_pass(column_pass(work));
      done = done + 2;
    end
    if (done < rounds_cfg) work = column_pass(work);
    for (i = 0; i < NumWords; i++) sum[i] = work[i] + start[i];
    return sum;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rounds_cfg <= RoundsReset;
      key_01     <= '0;
      key_23     <= '0;
      key_45     <= '0;
      key_67     <= '0;
      nonce_cfg  <= '0;
      keystream_due.delete();
      words_due  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ROUND_COUNT: rounds_cfg <= cfg_data_i[RoundW-1:0];
          CFG_KEY_01:      key_01     <= cfg_data_i;
          CFG_KEY_23:      key_23     <= cfg_data_i;
          CFG_KEY_45:      key_45     <= cfg_data_i;
          CFG_KEY_67:      key_67     <= cfg_data_i;
          CFG_NONCE:       nonce_cfg  <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predicted = keystream_block(block_counter_i);
        for (int i = 0; i < NumWords; i++) begin
          want.word  = predicted[i];
          want.index = i[IdxW-1:0];
          want.last  = (i == NumWords - 1);
          keystream_due.push_back(want);
        end
      end
      if (out_valid_i && !out_stall_i) begin
        got.word  = keystream_word_i;
        got.index = word_index_i;
        got.last  = last_word_i;
        if (keystream_due.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected keystream word %08h idx %0d last %0b",
                     got.word, got.index, got.last);
        end else begin
          want = keystream_due.pop_front();
          words_checked++;
          if (got !== want) begin
            failures++;
            if (failures <= 10)
              $display("word mismatch: expected %08h idx %0d last %0b, got %08h idx %0d last %0b",
                       want.word, want.index, want.last, got.word, got.index, got.last);
          end
        end
      end
      words_due <= keystream_due.size();
    end
  end

endmodule

@@ sim/tb_chacha_keystream_block_core.sv @@
// Testbench top for chacha_keystream_block_core: drives block counters and
// register writes with random idling and output stalls, and gives the verdict
// from chacha_keystream_checker. Depends on chacha_pkg and the core RTL.
module tb_chacha_keystream_block_core;

  import chacha_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;
  localparam int unsigned RandomItems = 200;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned EndWait     = 80;
  localparam int unsigned CycleLimit  = 1000000;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                in_valid_i      = 1'b0;
  logic                in_stall_o;
  logic [CounterW-1:0] block_counter_i = '0;
  logic                out_valid_o;
  logic                out_stall_i     = 1'b0;
  logic [WordW-1:0]    keystream_word_o;
  logic [IdxW-1:0]     word_index_o;
  logic                last_word_o;
  logic                cfg_valid_i     = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i      = '0;

  int unsigned failures;
  int unsigned words_due;
  int unsigned words_checked;
  int unsigned blocks_sent     = 0;
  int unsigned config_phases   = 0;
  int unsigned hold_asked      = 0;
  int unsigned hold_given      = 0;
  int unsigned stall_left      = 0;
  int unsigned stall_pick;
  logic        sender_steady   = 1'b0;
  logic        receiver_steady = 1'b0;

  chacha_keystream_block_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .block_counter_i (block_counter_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .keystream_word_o(keystream_word_o),
    .word_index_o    (word_index_o),
    .last_word_o     (last_word_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  chacha_keystream_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .block_counter_i (block_counter_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .keystream_word_i(keystream_word_o),
    .word_index_i    (word_index_o),
    .last_word_i     (last_word_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .failures_o      (failures),
    .words_due_o     (words_due),
    .words_checked_o (words_checked)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (hold_given != hold_asked) begin
      out_stall_i <= 1'b1;
      stall_left  <= LongHold - 1;
      hold_given  <= hold_given + 1;
    end else if (receiver_steady) begin
      out_stall_i <= 1'b0;
    end else begin
      stall_pick = $urandom_range(0, 19);
      if (stall_pick < 12) begin
        out_stall_i <= 1'b0;
      end else if (stall_pick < 19) begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(8, 40);
      end
    end
  end

  function automatic int unsigned next_gap();
    int unsigned pick;
    if (sender_steady) return 0;
    pick = $urandom_range(0, 15);
    if (pick < 8) return 0;
    if (pick < 14) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic logic [63:0] pick_value();
    int unsigned pick;
    pick = $urandom_range(0, 5);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [CounterW-1:0] pick_counter();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return {32'h0, $urandom};
    if (pick == 1) return {$urandom, 32'hFFFF_FFFF};
    if (pick == 2) return '1;
    if (pick == 3) return 64'($urandom_range(0, 15));
    return {$urandom, $urandom};
  endfunction

  function automatic logic [RoundW-1:0] pick_rounds();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick < 2) return 5'($urandom_range(0, 31));
    if (pick == 2) return 5'd31;
    if (pick == 3) return 5'd8;
    if (pick == 4) return 5'd12;
    return 5'd20;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [CfgDataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_config(input logic [CfgDataW-1:0] rounds_data, k01, k23, k45, k67,
                             nonce);
    write_reg(CFG_ROUND_COUNT, rounds_data);
    write_reg(CFG_KEY_01, k01);
    write_reg(CFG_KEY_23, k23);
    write_reg(CFG_KEY_45, k45);
    write_reg(CFG_KEY_67, k67);
    write_reg(CFG_NONCE, nonce);
    cfg_valid_i <= 1'b0;
    config_phases++;
  endtask

  task automatic send_block(input logic [CounterW-1:0] counter);
    int unsigned gap;
    in_valid_i      <= 1'b1;
    block_counter_i <= counter;
    do @(posedge clk_i); while (in_stall_o);
    blocks_sent++;
    gap = next_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic finish_phase();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (words_due != 0);
  endtask

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_chacha_keystream_block_core NOT OK");
    $finish;
  end

  initial begin : stimulus
    int unsigned        target;
    int unsigned        phase;
    int unsigned        phase_len;
    logic [CfgDataW-1:0] rounds_data;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_block('0);
    send_block('1);
    finish_phase();

    load_config(64'd20, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, {$urandom, $urandom});
    send_block(64'h0000_0000_0000_0001);
    send_block(64'h0000_0001_0000_0000);
    send_block(64'hFFFF_FFFF_0000_0000);
    finish_phase();

    load_config(64'd0, '1, '1, '1, '1, '1);
    send_block('1);
    send_block('0);
    finish_phase();

    load_config(64'd1, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, {$urandom, $urandom});
    send_block({$urandom, $urandom});
    finish_phase();

    load_config(64'd31, '1, '1, '1, '1, '1);
    send_block('1);
    finish_phase();

    load_config(64'd2, '0, '0, '0, '0, '0);
    send_block('0);
    finish_phase();

    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, {$urandom, $urandom});
    write_reg(CFG_ROUND_COUNT, 64'hFFFF_FFFF_FFFF_FFEC);
    cfg_valid_i <= 1'b0;
    config_phases++;
    send_block({$urandom, $urandom});
    finish_phase();

    load_config({32'hFFFF_FFFF, 32'hFFFF_FFE7}, {$urandom, $urandom}, '0, '1,
                {$urandom, $urandom}, 64'h8000_0000_0000_0001);
    send_block(64'h7FFF_FFFF_FFFF_FFFF);
    finish_phase();

    target = blocks_sent + RandomItems;
    phase  = 0;
    while (blocks_sent < target) begin
      rounds_data = {$urandom, $urandom};
      rounds_data[RoundW-1:0] = pick_rounds();
      write_reg(CFG_ROUND_COUNT, rounds_data);
      if ($urandom_range(0, 1) != 0) write_reg(CFG_KEY_01, pick_value());
      if ($urandom_range(0, 1) != 0) write_reg(CFG_KEY_23, pick_value());
      if ($urandom_range(0, 1) != 0) write_reg(CFG_KEY_45, pick_value());
      if ($urandom_range(0, 1) != 0) write_reg(CFG_KEY_67, pick_value());
      if ($urandom_range(0, 1) != 0) write_reg(CFG_NONCE, pick_value());
      if ($urandom_range(0, 5) == 0)
        write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO,
                  {$urandom, $urandom});
      cfg_valid_i <= 1'b0;
      config_phases++;

      phase_len     = $urandom_range(3, 16);
      sender_steady = ($urandom_range(0, 3) == 0);
      if (phase == 1) begin
        sender_steady   = 1'b1;
        receiver_steady <= 1'b0;
        hold_asked      <= hold_asked + 1;
        phase_len       = 12;
      end else begin
        receiver_steady <= ($urandom_range(0, 3) == 0);
      end
      repeat (phase_len) send_block(pick_counter());
      finish_phase();
      phase++;
    end

    repeat (EndWait) @(posedge clk_i);
    $display("Checked %0d keystream words from %0d blocks over %0d register settings,",
             words_checked, blocks_sent, config_phases);
    $display("covering 0 to 31 rounds, spare register indexes and a long output hold.");
    if (failures == 0 && words_due == 0) begin
      $display("tb_chacha_keystream_block_core OK");
    end else begin
      $display("tb_chacha_keystream_block_core NOT OK");
    end
    $finish;
  end

endmodule
